[rtl/tccb_pkg.sv]
// shared types, codes and defaults for the text console cursor buffer
// no dependencies; used by tccb_ctrl, tccb_dp and text_console_cursor_buffer
package tccb_pkg;

    // parameter defaults
    localparam int ROWS_DEF     = 16;
    localparam int COLS_DEF     = 64;
    localparam int TAB_STOP_DEF = 8;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] BS_RESET = 8'd8;

    // item kinds
    localparam logic [2:0] KIND_PUT   = 3'd0;
    localparam logic [2:0] KIND_CLEAR = 3'd1;
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_READ  = 3'd3;
    localparam logic [2:0] KIND_ACK   = 3'd4;

    // datapath operations
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_LOAD      = 3'd1;
    localparam logic [2:0] OP_EXEC      = 3'd2;
    localparam logic [2:0] OP_TAB       = 3'd3;
    localparam logic [2:0] OP_SWEEP_ROW = 3'd4;
    localparam logic [2:0] OP_SWEEP_ALL = 3'd5;
    localparam logic [2:0] OP_EMIT      = 3'd6;

    typedef struct packed {
        logic [2:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tab;
        logic is_clear;
        logic scroll;
        logic tab_last;
        logic row_sweep_last;
        logic all_sweep_last;
    } t_dp_status;

endpackage

[rtl/tccb_ctrl.sv]
// sequencing state machine for the text console cursor buffer
// depends on tccb_pkg for command and status types
module tccb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_strobe,
    output tccb_pkg::t_dp_cmd    o_cmd,
    input  tccb_pkg::t_dp_status i_status
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_TAB  = 3'd3;
    localparam logic [2:0] S_SCRL = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_strobe;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = tccb_pkg::OP_NONE;
        case (r_state)
            S_INIT: begin
                o_cmd.op = tccb_pkg::OP_SWEEP_ALL;
                if (i_status.all_sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = tccb_pkg::OP_LOAD;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.op = tccb_pkg::OP_EXEC;
                if (i_status.is_tab)        n_state = S_TAB;
                else if (i_status.is_clear) n_state = S_CLR;
                else if (i_status.scroll)   n_state = S_SCRL;
                else                        n_state = S_EMIT;
            end
            S_TAB: begin
                o_cmd.op = tccb_pkg::OP_TAB;
                if (i_status.tab_last) n_state = S_EMIT;
            end
            S_SCRL: begin
                o_cmd.op = tccb_pkg::OP_SWEEP_ROW;
                if (i_status.row_sweep_last) n_state = S_EMIT;
            end
            S_CLR: begin
                o_cmd.op = tccb_pkg::OP_SWEEP_ALL;
                if (i_status.all_sweep_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.op = tccb_pkg::OP_EMIT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EMIT);
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    // an accepted transaction holds the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low right after accept");

    // the strobe only follows the emit step
    a_strobe_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_EMIT)
        else $error("strobe without emit");

    // one result per transaction, never two in a row
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held for two cycles");

    // result cycle already open for the next transaction
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy during result cycle");

endmodule

[rtl/tccb_dp.sv]
// datapath: screen memory, cursor, dirty flags, sweep counters, result registers
// depends on tccb_pkg; driven by tccb_ctrl
module tccb_dp #(
    parameter int ROWS     = tccb_pkg::ROWS_DEF,
    parameter int COLS     = tccb_pkg::COLS_DEF,
    parameter int TAB_STOP = tccb_pkg::TAB_STOP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tccb_pkg::t_dp_cmd    i_cmd,
    output tccb_pkg::t_dp_status o_status,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic [2:0]           i_kind,
    input  logic [7:0]           i_char_code,
    input  logic [3:0]           i_read_row,
    input  logic [5:0]           i_read_col,
    output logic [5:0]           o_cursor_col,
    output logic [3:0]           o_cursor_row,
    output logic [3:0]           o_input_mark_row,
    output logic [7:0]           o_cell_char,
    output logic [15:0]          o_dirty_rows
);

    localparam int RW       = $clog2(ROWS);
    localparam int CW       = $clog2(COLS);
    localparam int AW       = RW + CW;
    localparam int DEPTH    = 1 << AW;
    localparam int TW       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int BS_PHASE = (COLS - 1) % TAB_STOP;

    function automatic logic [RW-1:0] f_phys(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (RW+1)'(ROWS)) sum = sum - (RW+1)'(ROWS);
        return sum[RW-1:0];
    endfunction

    // latched item
    logic [2:0]    r_kind;
    logic [7:0]    r_code;
    logic [3:0]    r_in_row;
    logic [5:0]    r_in_col;

    // screen state
    logic [CW-1:0]   r_cur_col, n_cur_col;
    logic [RW-1:0]   r_cur_row, n_cur_row;
    logic [RW-1:0]   r_mark, n_mark;
    logic [RW-1:0]   r_top, n_top;
    logic [TW-1:0]   r_phase, n_phase;
    logic [ROWS-1:0] r_dirty, n_dirty;
    logic [7:0]      r_bs_code;
    logic [AW-1:0]   r_swp_all, n_swp_all;
    logic [CW-1:0]   r_swp_col, n_swp_col;
    logic [RW-1:0]   r_swp_row, n_swp_row;

    // memory
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    // result registers
    logic [5:0]  r_o_col;
    logic [3:0]  r_o_row;
    logic [3:0]  r_o_mark;
    logic [7:0]  r_o_cell;
    logic [15:0] r_o_dirty;

    logic is_put, is_bs, is_tab, is_lf, is_cr, is_plain;
    logic col_last, row_last, do_ld, rd_ok, ack_ok;
    logic [RW-1:0] top_next, cur_phys;
    logic [TW-1:0] phase_inc, phase_dec;

    assign is_put   = (r_kind == tccb_pkg::KIND_PUT);
    assign is_bs    = is_put && (r_code == r_bs_code);
    assign is_tab   = is_put && !is_bs && (r_code == tccb_pkg::CH_TAB);
    assign is_lf    = is_put && !is_bs && (r_code == tccb_pkg::CH_LF);
    assign is_cr    = is_put && !is_bs && (r_code == tccb_pkg::CH_CR);
    assign is_plain = is_put && !is_bs && !is_tab && !is_lf && !is_cr;

    assign col_last  = (r_cur_col == CW'(COLS - 1));
    assign row_last  = (r_cur_row == RW'(ROWS - 1));
    assign top_next  = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
    assign cur_phys  = f_phys(r_cur_row, r_top);
    assign phase_inc = (r_phase == TW'(TAB_STOP - 1)) ? '0 : r_phase + 1'b1;
    assign phase_dec = (r_phase == '0) ? TW'(TAB_STOP - 1) : r_phase - 1'b1;

    assign rd_ok  = (32'(r_in_row) < ROWS) && (32'(r_in_col) < COLS);
    assign ack_ok = (32'(r_in_row) < ROWS);
    assign mem_raddr = {f_phys(RW'(r_in_row), r_top), CW'(r_in_col)};

    // line feed, a wrap past the last column, or start input off column 0
    assign do_ld = (is_plain && col_last) || is_lf
                || ((r_kind == tccb_pkg::KIND_START) && (r_cur_col != '0));

    assign o_status.is_tab         = is_tab;
    assign o_status.is_clear       = (r_kind == tccb_pkg::KIND_CLEAR);
    assign o_status.scroll         = do_ld && row_last;
    assign o_status.tab_last       = col_last || (r_phase == TW'(TAB_STOP - 1));
    assign o_status.row_sweep_last = (r_swp_col == CW'(COLS - 1));
    assign o_status.all_sweep_last = &r_swp_all;

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_mark    = r_mark;
        n_top     = r_top;
        n_phase   = r_phase;
        n_dirty   = r_dirty;
        n_swp_all = r_swp_all;
        n_swp_col = r_swp_col;
        n_swp_row = r_swp_row;
        mem_we    = 1'b0;
        mem_waddr = {cur_phys, r_cur_col};
        mem_wdata = tccb_pkg::CH_SPACE;
        case (i_cmd.op)
            tccb_pkg::OP_EXEC: begin
                case (r_kind)
                    tccb_pkg::KIND_PUT: begin
                        if (is_bs) begin
                            if (r_cur_col != '0) begin
                                n_cur_col = r_cur_col - 1'b1;
                                n_phase   = phase_dec;
                                mem_we    = 1'b1;
                                mem_waddr = {cur_phys, n_cur_col};
                                n_dirty[r_cur_row] = 1'b1;
                            end else if (r_cur_row > r_mark) begin
                                // back onto the end of the previous row
                                n_cur_row = r_cur_row - 1'b1;
                                n_cur_col = CW'(COLS - 1);
                                n_phase   = TW'(BS_PHASE);
                                mem_we    = 1'b1;
                                mem_waddr = {f_phys(n_cur_row, r_top), n_cur_col};
                                n_dirty[n_cur_row] = 1'b1;
                            end
                        end else if (is_tab) begin
                            n_dirty[r_cur_row] = 1'b1;
                        end else if (is_cr) begin
                            n_cur_col = '0;
                            n_phase   = '0;
                            n_dirty[r_cur_row] = 1'b1;
                        end else if (is_plain) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_code;
                            n_dirty[r_cur_row] = 1'b1;
                            if (!col_last) begin
                                n_cur_col = r_cur_col + 1'b1;
                                n_phase   = phase_inc;
                            end
                        end
                    end
                    tccb_pkg::KIND_CLEAR: begin
                        n_cur_col  = '0;
                        n_cur_row  = '0;
                        n_top      = '0;
                        n_phase    = '0;
                        n_dirty    = '0;
                        n_dirty[0] = 1'b1;
                        n_swp_all  = '0;
                    end
                    tccb_pkg::KIND_ACK: begin
                        if (ack_ok) n_dirty[RW'(r_in_row)] = 1'b0;
                    end
                    default: begin
                    end
                endcase
                if (do_ld) begin
                    n_cur_col = '0;
                    n_phase   = '0;
                    if (row_last) begin
                        // scroll: old top row becomes the blank bottom row
                        n_top     = top_next;
                        n_dirty   = '1;
                        n_mark    = (r_mark != '0) ? r_mark - 1'b1 : r_mark;
                        n_swp_row = r_top;
                        n_swp_col = '0;
                    end else begin
                        n_cur_row = r_cur_row + 1'b1;
                    end
                end
                if (r_kind == tccb_pkg::KIND_START) n_mark = n_cur_row;
            end
            tccb_pkg::OP_TAB: begin
                mem_we = 1'b1;
                if (!col_last) begin
                    n_cur_col = r_cur_col + 1'b1;
                    n_phase   = phase_inc;
                end
            end
            tccb_pkg::OP_SWEEP_ROW: begin
                mem_we    = 1'b1;
                mem_waddr = {r_swp_row, r_swp_col};
                n_swp_col = r_swp_col + 1'b1;
            end
            tccb_pkg::OP_SWEEP_ALL: begin
                mem_we    = 1'b1;
                mem_waddr = r_swp_all;
                n_swp_all = r_swp_all + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_mark    <= '0;
            r_top     <= '0;
            r_phase   <= '0;
            r_dirty   <= '0;
            r_swp_all <= '0;
            r_swp_col <= '0;
            r_swp_row <= '0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_mark    <= n_mark;
            r_top     <= n_top;
            r_phase   <= n_phase;
            r_dirty   <= n_dirty;
            r_swp_all <= n_swp_all;
            r_swp_col <= n_swp_col;
            r_swp_row <= n_swp_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs_code <= tccb_pkg::BS_RESET;
        end else if (i_cfg_we) begin
            r_bs_code <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tccb_pkg::OP_LOAD) begin
            r_kind   <= i_kind;
            r_code   <= i_char_code;
            r_in_row <= i_read_row;
            r_in_col <= i_read_col;
        end
        if (i_cmd.op == tccb_pkg::OP_EMIT) begin
            r_o_col   <= 6'(r_cur_col);
            r_o_row   <= 4'(r_cur_row);
            r_o_mark  <= 4'(r_mark);
            r_o_cell  <= ((r_kind == tccb_pkg::KIND_READ) && rd_ok) ? r_rdata : 8'd0;
            r_o_dirty <= 16'(r_dirty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_cursor_col     = r_o_col;
    assign o_cursor_row     = r_o_row;
    assign o_input_mark_row = r_o_mark;
    assign o_cell_char      = r_o_cell;
    assign o_dirty_rows     = r_o_dirty;

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_row <= RW'(ROWS - 1) && r_top <= RW'(ROWS - 1))
        else $error("cursor or top row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col <= CW'(COLS - 1) && r_phase <= TW'(TAB_STOP - 1))
        else $error("cursor column or tab phase out of range");

endmodule

[rtl/text_console_cursor_buffer.sv]
// top level of the text console cursor buffer
// instantiates tccb_ctrl and tccb_dp; types and defaults from tccb_pkg
//
// channel    direction  handshake                 payload
// command    in         start, busy               i_kind, i_char_code, i_read_row, i_read_col
// result     out        o_strobe (one cycle)      o_cursor_col, o_cursor_row,
//                                                 o_input_mark_row, o_cell_char, o_dirty_rows
// config     in         i_cfg_we                  i_cfg_wdata (backspace code)
//
// a transaction is taken when start is high and busy low; its result shows for one
// cycle with o_strobe, and busy is already low in that cycle
// most items pass through latch, execute and emit before the next accept
// tab adds one memory write per padded column, up to the next tab stop or the last column
// a scroll adds a sweep that blanks the new bottom row through the single write port
// clear screen adds a full sweep of 2**(clog2(ROWS)+clog2(COLS)) words (1024 by default)
// after reset the same full sweep runs with busy high; backspace code resets to 8
// scrolling moves a top-row pointer, so no row copy is ever needed
module text_console_cursor_buffer #(
    parameter int ROWS     = tccb_pkg::ROWS_DEF,
    parameter int COLS     = tccb_pkg::COLS_DEF,
    parameter int TAB_STOP = tccb_pkg::TAB_STOP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_read_row,
    input  logic [5:0]  i_read_col,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // result side
    output logic        o_strobe,
    output logic [5:0]  o_cursor_col,
    output logic [3:0]  o_cursor_row,
    output logic [3:0]  o_input_mark_row,
    output logic [7:0]  o_cell_char,
    output logic [15:0] o_dirty_rows
);

    // command and status between sequencer and datapath
    tccb_pkg::t_dp_cmd    dp_cmd;
    tccb_pkg::t_dp_status dp_status;

    // sequencer: picks one datapath operation per cycle
    tccb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    // datapath: screen memory, cursor, dirty flags and result registers
    tccb_dp #(
        .ROWS     (ROWS),
        .COLS     (COLS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_kind),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_input_mark_row (o_input_mark_row),
        .o_cell_char      (o_cell_char),
        .o_dirty_rows     (o_dirty_rows)
    );

endmodule

[tb/sv/tb_text_console_cursor_buffer.sv]
// testbench for text_console_cursor_buffer: random and directed console traffic,
// checked against a behavioral screen model held in a small scoreboard class
// depends on tccb_pkg and the text_console_cursor_buffer rtl
`timescale 1ns / 100ps

module tb_text_console_cursor_buffer;

    localparam int SCREEN_ROWS = tccb_pkg::ROWS_DEF;
    localparam int SCREEN_COLS = tccb_pkg::COLS_DEF;
    localparam int TAB_WIDTH   = tccb_pkg::TAB_STOP_DEF;

    // kinds above KIND_ACK are unused by the block and must leave the state alone
    localparam logic [2:0] KIND_SPARE_LO = tccb_pkg::KIND_ACK + 3'd1;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int MAX_PRINTED     = 100;

    typedef struct packed {
        logic [5:0]  cursor_col;
        logic [3:0]  cursor_row;
        logic [3:0]  mark_row;
        logic [7:0]  cell_char;
        logic [15:0] dirty_rows;
    } t_console_result;

    // ------------------------------------------------------------------
    // screen model and result scoreboard
    // ------------------------------------------------------------------
    class t_console_scoreboard;
        logic [7:0]             screen [SCREEN_ROWS][SCREEN_COLS];
        int                     cur_col;
        int                     cur_row;
        int                     mark_row;
        logic [SCREEN_ROWS-1:0] dirty;
        logic [7:0]             bs_code;
        t_console_result        expected_q[$];
        int                     fail_count;

        function new();
            blank_screen();
            dirty      = '0;
            cur_col    = 0;
            cur_row    = 0;
            mark_row   = 0;
            bs_code    = tccb_pkg::BS_RESET;
            fail_count = 0;
        endfunction

        function void blank_screen();
            foreach (screen[r, c]) screen[r][c] = tccb_pkg::CH_SPACE;
        endfunction

        function void set_backspace(logic [7:0] code);
            bs_code = code;
        endfunction

        // shift every row up one, blank the bottom row, everything dirty, mark row up one
        function void scroll_up();
            for (int r = 0; r < SCREEN_ROWS - 1; r++) screen[r] = screen[r + 1];
            for (int c = 0; c < SCREEN_COLS; c++)
                screen[SCREEN_ROWS - 1][c] = tccb_pkg::CH_SPACE;
            dirty = '1;
            if (mark_row > 0) mark_row--;
        endfunction

        function void line_down();
            cur_row++;
            if (cur_row >= SCREEN_ROWS) begin
                scroll_up();
                cur_row = SCREEN_ROWS - 1;
            end
            cur_col = 0;
        endfunction

        function void put_char(logic [7:0] ch);
            int pad;
            // backspace code wins over tab, newline and carriage return
            if (ch == bs_code) begin
                if (cur_col == 0) begin
                    if (cur_row > 0 && cur_row > mark_row) begin
                        cur_row--;
                        cur_col = SCREEN_COLS;
                    end else begin
                        return;
                    end
                end
                cur_col--;
                screen[cur_row][cur_col] = tccb_pkg::CH_SPACE;
                dirty[cur_row] = 1'b1;
            end else if (ch == tccb_pkg::CH_TAB) begin
                pad = TAB_WIDTH - (cur_col % TAB_WIDTH);
                dirty[cur_row] = 1'b1;
                for (int i = 0; i < pad; i++) begin
                    screen[cur_row][cur_col] = tccb_pkg::CH_SPACE;
                    cur_col++;
                    // tab never leaves the last column
                    if (cur_col == SCREEN_COLS) begin
                        cur_col--;
                        break;
                    end
                end
            end else if (ch == tccb_pkg::CH_LF) begin
                line_down();
            end else if (ch == tccb_pkg::CH_CR) begin
                cur_col = 0;
                dirty[cur_row] = 1'b1;
            end else begin
                screen[cur_row][cur_col] = ch;
                dirty[cur_row] = 1'b1;
                cur_col++;
                if (cur_col >= SCREEN_COLS) line_down();
            end
        endfunction

        // an accepted transaction: update the model and queue its result
        function void note_command(logic [2:0] kind, logic [7:0] code,
                                   logic [3:0] row, logic [5:0] col);
            t_console_result res;
            logic [7:0]      cell_val;
            cell_val = 8'd0;
            case (kind)
                tccb_pkg::KIND_PUT: put_char(code);
                tccb_pkg::KIND_CLEAR: begin
                    blank_screen();
                    dirty    = '0;
                    dirty[0] = 1'b1;
                    cur_col  = 0;
                    cur_row  = 0;
                end
                tccb_pkg::KIND_START: begin
                    if (cur_col > 0) line_down();
                    mark_row = cur_row;
                end
                tccb_pkg::KIND_READ: begin
                    if (int'(row) < SCREEN_ROWS && int'(col) < SCREEN_COLS)
                        cell_val = screen[row][col];
                end
                tccb_pkg::KIND_ACK: begin
                    if (int'(row) < SCREEN_ROWS) dirty[row] = 1'b0;
                end
                default: ;
            endcase
            res.cursor_col = cur_col[5:0];
            res.cursor_row = cur_row[3:0];
            res.mark_row   = mark_row[3:0];
            res.cell_char  = cell_val;
            res.dirty_rows = 16'(dirty);
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            if (fail_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_console_result got);
            t_console_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result strobe with no transaction outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.cursor_col !== want.cursor_col)
                report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                          got.cursor_col, want.cursor_col));
            if (got.cursor_row !== want.cursor_row)
                report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                          got.cursor_row, want.cursor_row));
            if (got.mark_row !== want.mark_row)
                report_mismatch($sformatf("input_mark_row got %0d expected %0d",
                                          got.mark_row, want.mark_row));
            if (got.cell_char !== want.cell_char)
                report_mismatch($sformatf("cell_char got %0h expected %0h",
                                          got.cell_char, want.cell_char));
            if (got.dirty_rows !== want.dirty_rows)
                report_mismatch($sformatf("dirty_rows got %04h expected %04h",
                                          got.dirty_rows, want.dirty_rows));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [2:0]  i_kind      = tccb_pkg::KIND_PUT;
    logic [7:0]  i_char_code = 8'd0;
    logic [3:0]  i_read_row  = 4'd0;
    logic [5:0]  i_read_col  = 6'd0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        busy;
    logic        o_strobe;
    logic [5:0]  o_cursor_col;
    logic [3:0]  o_cursor_row;
    logic [3:0]  o_input_mark_row;
    logic [7:0]  o_cell_char;
    logic [15:0] o_dirty_rows;

    always #5 i_clk = ~i_clk;

    text_console_cursor_buffer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_input_mark_row (o_input_mark_row),
        .o_cell_char      (o_cell_char),
        .o_dirty_rows     (o_dirty_rows)
    );

    t_console_scoreboard sb = new();

    // results are taken at the edge that ends their strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result({o_cursor_col, o_cursor_row, o_input_mark_row,
                             o_cell_char, o_dirty_rows});
    end

    // ------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------
    int items_sent = 0;
    int burst_left = 0;

    // drive one transaction, hold start until it is taken, then maybe pause
    task send_item(logic [2:0] kind, logic [7:0] code, logic [3:0] row, logic [5:0] col);
        int gap;
        i_kind      <= kind;
        i_char_code <= code;
        i_read_row  <= row;
        i_read_col  <= col;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(kind, code, row, col);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // new burst; some bursts run back to back with no gap at all
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 15);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // put-char transaction with don't-care fields randomized
    task send_put(logic [7:0] ch);
        send_item(tccb_pkg::KIND_PUT, ch, 4'($urandom), 6'($urandom));
    endtask

    // drop start and wait for every outstanding result
    task wait_idle();
        start <= 1'b0;
        while (sb.expected_q.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task write_backspace(logic [7:0] code);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_backspace(code);
    endtask

    // short hand-picked sequence covering the corner cases
    task run_directed();
        send_item(tccb_pkg::KIND_READ, 8'hA5, 4'd0, 6'd0);    // reset contents
        send_item(tccb_pkg::KIND_READ, 8'h5A, 4'd15, 6'd63);  // far corner
        send_put(sb.bs_code);                           // backspace at home does nothing
        send_put(8'h00);
        send_put(8'hFF);
        send_put("A");
        send_put(sb.bs_code);                           // blank the 'A'
        send_put(tccb_pkg::CH_TAB);
        send_put(tccb_pkg::CH_CR);
        send_put(tccb_pkg::CH_LF);                      // newline alone marks nothing dirty
        send_item(tccb_pkg::KIND_START, 8'h00, 4'h0, 6'h00);  // start at column 0
        send_put("x");
        send_item(tccb_pkg::KIND_START, 8'hFF, 4'hF, 6'h3F);  // start mid-line moves down
        send_put(sb.bs_code);                           // blocked by the mark row
        send_put(tccb_pkg::CH_LF);
        send_put(sb.bs_code);                           // back onto the end of the row above
        send_item(tccb_pkg::KIND_READ, 8'h00, 4'd0, 6'd1);
        send_item(tccb_pkg::KIND_ACK, 8'h00, 4'd15, 6'd0);
        send_item(tccb_pkg::KIND_ACK, 8'hFF, 4'd0, 6'd63);
        send_item(KIND_SPARE_LO, 8'($urandom), 4'($urandom), 6'($urandom));
        send_item(KIND_SPARE_HI, 8'($urandom), 4'($urandom), 6'($urandom));
        send_item(tccb_pkg::KIND_CLEAR, 8'h00, 4'h0, 6'h00);  // mark row survives the clear
        send_item(tccb_pkg::KIND_READ, 8'h00, 4'd0, 6'd1);
    endtask

    // tabs and characters up to the last column, then a tab that must stay put
    task run_tab_to_edge();
        while (sb.cur_col != SCREEN_COLS - 1) begin
            // a tab that doubles as backspace would walk the cursor back
            if (sb.cur_col < SCREEN_COLS - TAB_WIDTH && sb.bs_code != tccb_pkg::CH_TAB)
                send_put(tccb_pkg::CH_TAB);
            else send_put(8'($urandom_range(33, 126)));
        end
        send_put(tccb_pkg::CH_TAB);
    endtask

    // mostly console-like text with line control, the rest noise
    task run_console_traffic(int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 52) send_put(8'($urandom_range(32, 126)));
            else if (pick < 60) send_put(tccb_pkg::CH_LF);
            else if (pick < 66) send_put(sb.bs_code);
            else if (pick < 69) send_put(tccb_pkg::CH_TAB);
            else if (pick < 71) send_put(tccb_pkg::CH_CR);
            else if (pick < 75) send_put(8'($urandom));
            else if (pick < 78) send_item(tccb_pkg::KIND_START, 8'($urandom),
                                          4'($urandom), 6'($urandom));
            else if (pick < 83) send_item(tccb_pkg::KIND_READ, 8'($urandom),
                                          4'($urandom), 6'($urandom));
            else if (pick < 86) send_item(tccb_pkg::KIND_READ, 8'($urandom),
                                          4'(sb.cur_row), 6'($urandom));
            else if (pick < 91) send_item(tccb_pkg::KIND_ACK, 8'($urandom),
                                          4'($urandom), 6'($urandom));
            else if (pick < 93) send_item(tccb_pkg::KIND_CLEAR, 8'($urandom),
                                          4'($urandom), 6'($urandom));
            else if (pick < 95) repeat ($urandom_range(40, 70))
                                    send_put(8'($urandom_range(32, 126)));
            else if (pick < 96) run_tab_to_edge();
            else send_item(3'($urandom), 8'($urandom), 4'($urandom), 6'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the backspace code first, then a sweep of settings
        run_directed();
        run_console_traffic(ITEMS_PER_PHASE);
        write_backspace(8'd0);
        run_console_traffic(ITEMS_PER_PHASE);
        write_backspace(8'd255);
        run_console_traffic(ITEMS_PER_PHASE);
        // backspace code equal to tab, newline or return takes precedence
        write_backspace(tccb_pkg::CH_TAB);
        run_console_traffic(ITEMS_PER_PHASE / 3);
        write_backspace(tccb_pkg::CH_LF);
        run_console_traffic(ITEMS_PER_PHASE / 3);
        write_backspace(tccb_pkg::CH_CR);
        run_console_traffic(ITEMS_PER_PHASE / 3);
        write_backspace(8'($urandom_range(32, 126)));
        run_console_traffic(ITEMS_PER_PHASE);
        write_backspace(tccb_pkg::BS_RESET);
        run_console_traffic(ITEMS_PER_PHASE);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch("results still outstanding at end of run");
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // generous bound: every transaction a full clear sweep plus the longest gap
    initial begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/tccb_pkg.sv
rtl/tccb_ctrl.sv
rtl/tccb_dp.sv
rtl/text_console_cursor_buffer.sv
tb/sv/tb_text_console_cursor_buffer.sv
